>>> hdl/pfe_pkg.sv
// Package for the Playfair digraph encryptor: codes, constants, command and
// status structs, and small helper functions for coordinates and letters.
// Depends on nothing; every module imports it.
package pfe_pkg;

    localparam int SQ_DIM   = 5;
    localparam int SQ_CELLS = SQ_DIM * SQ_DIM;
    localparam int ALPHA    = 26;

    // ASCII codes
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7a;
    localparam logic [7:0] C_LOWER_X = 8'h78;
    localparam logic [6:0] C_UPPER_A = 7'h41;

    // Letter indexes and square bounds
    localparam logic [4:0] C_LETTER_Q    = 5'd16;
    localparam logic [4:0] C_LAST_LETTER = 5'd25;
    localparam logic [4:0] C_FULL        = 5'd25;
    localparam logic [2:0] C_LAST_COORD  = 3'd4;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_KEY   = 3'd1,
        OP_DONE  = 3'd2,
        OP_MSG   = 3'd3,
        OP_END   = 3'd4
    } t_opcode;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_coord;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_rc;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic key_append;
        logic walk_start;
        logic walk_step;
        logic hold_char;
        logic pair_msg;
        logic pair_end;
        logic look_a;
        logic look_b;
        logic read_a;
        logic read_b;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pend_valid;
        logic char_space;
        logic walk_last;
        logic out_free;
    } t_status;

    // Step a coordinate to the next one along, wrapping at the square edge
    function automatic t_coord wrap_inc(input t_coord v);
        wrap_inc = (v == C_LAST_COORD) ? 3'd0 : t_coord'(v + 3'd1);
    endfunction

    // Linear cell index: row * 5 + col
    function automatic logic [4:0] cell_index(input t_rc p);
        cell_index = {p.row, 2'b00} + {2'b00, p.row} + {2'b00, p.col};
    endfunction

    function automatic logic is_lower(input logic [7:0] ch);
        is_lower = (ch >= C_LOWER_A) && (ch <= C_LOWER_Z);
    endfunction

    function automatic t_letter letter_of(input logic [7:0] ch);
        logic [7:0] diff;
        diff      = ch - C_LOWER_A;
        letter_of = diff[4:0];
    endfunction

endpackage

>>> hdl/pfe_in_if.sv
// Input channel of the Playfair encryptor: valid/ready plus opcode and byte.
// Depends on nothing.
interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

>>> hdl/pfe_out_if.sv
// Output channel of the Playfair encryptor: valid/ready plus one cipher pair.
// Depends on nothing.
interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] first_cipher;
    logic [6:0] second_cipher;
    logic       bad_letter;

    modport source (output valid, output first_cipher, output second_cipher,
                    output bad_letter, input ready);
    modport sink   (input valid, input first_cipher, input second_cipher,
                    input bad_letter, output ready);
endinterface

>>> hdl/pfe_datapath.sv
// Datapath of the Playfair encryptor: key square, letter position table,
// pending letter, pair lookup and the output register. Depends on pfe_pkg.
module pfe_datapath
    import pfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [7:0] i_char,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [6:0] o_first,
    output logic [6:0] o_second,
    output logic       o_bad
);

    // Square contents, cell to letter, and letter to position
    t_letter          r_square [SQ_CELLS];
    t_rc              r_pos    [ALPHA];
    logic [ALPHA-1:0] r_placed;
    logic [4:0]       r_fill;
    t_rc              r_fill_rc;
    t_letter          r_walk;

    logic [7:0]       r_pend_char;
    logic             r_pend_valid;
    logic [7:0]       r_char_a;
    logic [7:0]       r_char_b;
    t_rc              r_rc_a;
    t_rc              r_rc_b;
    logic             r_bad;
    t_letter          r_let_a;
    t_letter          r_let_b;

    logic             r_out_valid;
    logic [6:0]       r_first;
    logic [6:0]       r_second;
    logic             r_out_bad;

    t_letter          app_letter;
    logic             app_ok;
    logic [7:0]       look_char;
    t_letter          look_letter;
    logic             look_hit;
    logic             same_row;
    logic             same_col;
    t_rc              tgt_a;
    t_rc              tgt_b;
    t_rc              rd_rc;
    logic [4:0]       rd_idx;
    logic             rd_valid;

    // Append: a key letter or the walk letter, if new, not q, and the square has room
    always_comb begin
        app_letter = i_cmd.walk_step ? r_walk : letter_of(i_char);
        app_ok     = (i_cmd.walk_step || (i_cmd.key_append && is_lower(i_char)))
                     && !r_placed[app_letter]
                     && (app_letter != C_LETTER_Q)
                     && (r_fill != C_FULL);
    end

    // Lookup of one pair byte in the position table
    always_comb begin
        look_char   = i_cmd.look_b ? r_char_b : r_char_a;
        look_letter = letter_of(look_char);
        look_hit    = is_lower(look_char) && r_placed[look_letter];
    end

    // Target cells by the same-row, same-column or rectangle rule
    always_comb begin
        same_row = (r_rc_a.row == r_rc_b.row);
        same_col = (r_rc_a.col == r_rc_b.col);
        if (same_row) begin
            tgt_a = '{row: r_rc_a.row, col: wrap_inc(r_rc_a.col)};
            tgt_b = '{row: r_rc_b.row, col: wrap_inc(r_rc_b.col)};
        end else if (same_col) begin
            tgt_a = '{row: wrap_inc(r_rc_a.row), col: r_rc_a.col};
            tgt_b = '{row: wrap_inc(r_rc_b.row), col: r_rc_b.col};
        end else begin
            tgt_a = '{row: r_rc_a.row, col: r_rc_b.col};
            tgt_b = '{row: r_rc_b.row, col: r_rc_a.col};
        end
        rd_rc    = i_cmd.read_b ? tgt_b : tgt_a;
        rd_idx   = cell_index(rd_rc);
        rd_valid = (rd_idx < r_fill);
    end

    // Square and position table storage
    always_ff @(posedge i_clk) begin
        if (app_ok) begin
            r_square[cell_index(r_fill_rc)] <= app_letter;
            r_pos[app_letter]               <= r_fill_rc;
        end
    end

    // Fill state, walk counter and placed bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_placed  <= '0;
            r_fill    <= '0;
            r_fill_rc <= '0;
            r_walk    <= '0;
        end else begin
            if (app_ok) begin
                r_placed[app_letter] <= 1'b1;
                r_fill               <= r_fill + 5'd1;
                if (r_fill_rc.col == C_LAST_COORD) begin
                    r_fill_rc.col <= '0;
                    r_fill_rc.row <= r_fill_rc.row + 3'd1;
                end else begin
                    r_fill_rc.col <= r_fill_rc.col + 3'd1;
                end
            end
            if (i_cmd.walk_start) begin
                r_walk <= '0;
            end else if (i_cmd.walk_step) begin
                r_walk <= r_walk + 5'd1;
            end
        end
    end

    // Pending letter flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.hold_char) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.pair_end) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pair_msg && (i_char != r_pend_char)) begin
            r_pend_valid <= 1'b0;
        end
    end

    // Pair bytes, lookups and square reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_char) begin
            r_pend_char <= i_char;
        end
        if (i_cmd.pair_msg) begin
            r_char_a <= r_pend_char;
            r_char_b <= (i_char == r_pend_char) ? C_LOWER_X : i_char;
        end
        if (i_cmd.pair_end) begin
            r_char_a <= r_pend_char;
            r_char_b <= C_LOWER_X;
        end
        if (i_cmd.look_a) begin
            r_rc_a <= r_pos[look_letter];
            r_bad  <= !look_hit;
        end
        if (i_cmd.look_b) begin
            r_rc_b <= r_pos[look_letter];
            r_bad  <= r_bad || !look_hit;
        end
        if (i_cmd.read_a) begin
            r_let_a <= rd_valid ? r_square[rd_idx] : '0;
        end
        if (i_cmd.read_b) begin
            r_let_b <= rd_valid ? r_square[rd_idx] : '0;
        end
    end

    // Output register: load on emit, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_bad <= r_bad;
            r_first   <= r_bad ? 7'd0 : C_UPPER_A + {2'b00, r_let_a};
            r_second  <= r_bad ? 7'd0 : C_UPPER_A + {2'b00, r_let_b};
        end
    end

    assign o_status.pend_valid = r_pend_valid;
    assign o_status.char_space = (i_char == C_SPACE);
    assign o_status.walk_last  = (r_walk == C_LAST_LETTER);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_first     = r_first;
    assign o_second    = r_second;
    assign o_bad       = r_out_bad;

endmodule

>>> hdl/pfe_ctrl.sv
// Controller of the Playfair encryptor: decodes opcodes and sequences the
// key walk and the pair lookup. Depends on pfe_pkg.
module pfe_ctrl
    import pfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_opcode,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LOOK_A,
        S_LOOK_B,
        S_READ_A,
        S_READ_B,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Decode and sequence
    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE);
        accept     = i_in_valid && o_in_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_START: begin
                            o_cmd.clear = 1'b1;
                        end
                        OP_KEY: begin
                            o_cmd.key_append = 1'b1;
                        end
                        OP_DONE: begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                        OP_MSG: begin
                            if (!i_status.char_space) begin
                                if (!i_status.pend_valid) begin
                                    o_cmd.hold_char = 1'b1;
                                end else begin
                                    o_cmd.pair_msg = 1'b1;
                                    n_state        = S_LOOK_A;
                                end
                            end
                        end
                        OP_END: begin
                            if (i_status.pend_valid) begin
                                o_cmd.pair_end = 1'b1;
                                n_state        = S_LOOK_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK_A: begin
                o_cmd.look_a = 1'b1;
                n_state      = S_LOOK_B;
            end
            S_LOOK_B: begin
                o_cmd.look_b = 1'b1;
                n_state      = S_READ_A;
            end
            S_READ_A: begin
                o_cmd.read_a = 1'b1;
                n_state      = S_READ_B;
            end
            S_READ_B: begin
                o_cmd.read_b = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/playfair_digraph_encryptor.sv
// Top level of the Playfair digraph encryptor: joins controller, datapath
// and the two channel interfaces. Depends on pfe_pkg, pfe_in_if, pfe_out_if.
//
//  channel  dir  payload                                   per transaction
//  i_in     in   opcode[2:0], char_code[7:0]               one command
//  o_out    out  first_cipher[6:0], second_cipher[6:0],    one enciphered pair
//                bad_letter
//
// Start, key byte, message-byte-without-result and message end without a
// pending letter finish on acceptance. Key done runs the fill walk, which
// visits the 26 letters one per cycle. A completed pair steps through two
// position lookups and two square reads on single ports, then emits.
// Reset clears the square, the used-letter bits and any pending letter.
// A full output register holds the sequencer in its emit step; the next
// command is still taken while a result waits to be collected.
module playfair_digraph_encryptor
    import pfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_in_if.sink    i_in,
    pfe_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_opcode   (i_in.opcode),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfe_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_char      (i_in.char_code),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_first     (o_out.first_cipher),
        .o_second    (o_out.second_cipher),
        .o_bad       (o_out.bad_letter)
    );

endmodule

>>> bench/pfe_cipher_checker.sv
// Checker for the Playfair digraph encryptor: watches both channels, keeps its
// own key square and pending letter, and compares every cipher pair.
// Depends on pfe_pkg, pfe_in_if and pfe_out_if.
module pfe_cipher_checker
    import pfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pfe_in_if    i_cmd,
    pfe_out_if   i_pair,
    output int   o_fail_count,
    output int   o_waiting
);

    typedef struct packed {
        logic [6:0] first_cipher;
        logic [6:0] second_cipher;
        logic       bad_letter;
    } t_cipher_pair;

    // Shadow copy of the key square and message pairing state
    t_letter      square_cells [SQ_CELLS];
    logic         used_map     [ALPHA];
    int           placed_count;
    logic [7:0]   held_byte;
    logic         held_valid;

    t_cipher_pair cipher_queue [$];
    t_cipher_pair oldest_pair;

    // Empty the square, mark only q as taken and drop any held letter
    function automatic void clear_square();
        for (int i = 0; i < SQ_CELLS; i++) square_cells[i] = '0;
        for (int i = 0; i < ALPHA; i++) used_map[i] = 1'b0;
        used_map[C_LETTER_Q] = 1'b1;
        placed_count = 0;
        held_byte    = '0;
        held_valid   = 1'b0;
    endfunction

    // Place a letter in the next free cell unless taken or the square is full
    function automatic void place_letter(input int idx);
        if (idx < ALPHA && !used_map[idx] && placed_count < SQ_CELLS) begin
            used_map[idx] = 1'b1;
            square_cells[placed_count] = t_letter'(idx);
            placed_count++;
        end
    endfunction

    // Cell of a byte among the placed cells, or -1 when absent
    function automatic int find_position(input logic [7:0] ch);
        if (ch < C_LOWER_A || ch > C_LOWER_Z) return -1;
        for (int i = 0; i < placed_count; i++)
            if (square_cells[i] == t_letter'(ch - C_LOWER_A)) return i;
        return -1;
    endfunction

    function automatic t_cipher_pair encipher_pair(input logic [7:0] a, input logic [7:0] b);
        int           pa, pb, r1, c1, r2, c2, swap;
        t_cipher_pair res;
        pa = find_position(a);
        pb = find_position(b);
        if (pa < 0 || pb < 0) begin
            res = '{first_cipher: 7'd0, second_cipher: 7'd0, bad_letter: 1'b1};
            return res;
        end
        r1 = pa / SQ_DIM;
        c1 = pa % SQ_DIM;
        r2 = pb / SQ_DIM;
        c2 = pb % SQ_DIM;
        if (r1 == r2) begin
            // same row: take the right neighbour, wrapping
            c1 = (c1 + 1) % SQ_DIM;
            c2 = (c2 + 1) % SQ_DIM;
        end else if (c1 == c2) begin
            // same column: take the cell below, wrapping
            r1 = (r1 + 1) % SQ_DIM;
            r2 = (r2 + 1) % SQ_DIM;
        end else begin
            // rectangle: swap the columns
            swap = c1;
            c1   = c2;
            c2   = swap;
        end
        res.first_cipher  = 7'(square_cells[r1 * SQ_DIM + c1]) + C_UPPER_A;
        res.second_cipher = 7'(square_cells[r2 * SQ_DIM + c2]) + C_UPPER_A;
        res.bad_letter    = 1'b0;
        return res;
    endfunction

    // Advance the shadow state by one command and queue any cipher pair
    function automatic void predict_command(input logic [2:0] op, input logic [7:0] ch);
        case (op)
            OP_START: clear_square();
            OP_KEY: begin
                if (ch >= C_LOWER_A && ch <= C_LOWER_Z) place_letter(int'(ch - C_LOWER_A));
            end
            OP_DONE: begin
                for (int k = 0; k < ALPHA; k++) place_letter(k);
            end
            OP_MSG: begin
                if (ch == C_SPACE) begin
                    // spaces are skipped
                end else if (!held_valid) begin
                    held_byte  = ch;
                    held_valid = 1'b1;
                end else if (ch == held_byte) begin
                    // doubled letter: pair with x and keep it held
                    cipher_queue.push_back(encipher_pair(held_byte, C_LOWER_X));
                end else begin
                    cipher_queue.push_back(encipher_pair(held_byte, ch));
                    held_byte  = '0;
                    held_valid = 1'b0;
                end
            end
            OP_END: begin
                if (held_valid) cipher_queue.push_back(encipher_pair(held_byte, C_LOWER_X));
                held_byte  = '0;
                held_valid = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Check results first, then predict from the accepted command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_square();
            cipher_queue.delete();
            o_fail_count = 0;
            o_waiting   <= 0;
        end else begin
            if (i_pair.valid && i_pair.ready) begin
                if (cipher_queue.size() == 0) begin
                    $error("cipher pair with none expected: first_cipher %0d second_cipher %0d bad_letter %0d",
                           i_pair.first_cipher, i_pair.second_cipher, i_pair.bad_letter);
                    o_fail_count++;
                end else begin
                    oldest_pair = cipher_queue.pop_front();
                    if (oldest_pair.first_cipher !== i_pair.first_cipher) begin
                        $error("first_cipher: expected %0d, got %0d",
                               oldest_pair.first_cipher, i_pair.first_cipher);
                        o_fail_count++;
                    end
                    if (oldest_pair.second_cipher !== i_pair.second_cipher) begin
                        $error("second_cipher: expected %0d, got %0d",
                               oldest_pair.second_cipher, i_pair.second_cipher);
                        o_fail_count++;
                    end
                    if (oldest_pair.bad_letter !== i_pair.bad_letter) begin
                        $error("bad_letter: expected %0d, got %0d",
                               oldest_pair.bad_letter, i_pair.bad_letter);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) predict_command(i_cmd.opcode, i_cmd.char_code);
            o_waiting <= cipher_queue.size();
        end
    end

endmodule

>>> bench/tb_playfair_digraph_encryptor.sv
// Testbench top for the Playfair digraph encryptor: clock, reset, command
// stimulus, receiver stalls and the verdict. Depends on pfe_pkg, both channel
// interfaces, playfair_digraph_encryptor and pfe_cipher_checker.
module tb_playfair_digraph_encryptor;
    import pfe_pkg::*;

    // Opcodes the block must ignore
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int PHASE_COMMANDS = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int waiting_pairs;
    int accepted_count = 0;
    int tx_idle_pct    = 29;
    int rx_idle_pct    = 47;
    bit hold_req       = 1'b0;

    pfe_in_if  cmd_ch ();
    pfe_out_if pair_ch ();

    playfair_digraph_encryptor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (pair_ch)
    );

    pfe_cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_pair       (pair_ch),
        .o_fail_count (fail_count),
        .o_waiting    (waiting_pairs)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop should the block hang
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        pair_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pair_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                pair_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                pair_ch.ready <= 1'b0;
            end else begin
                pair_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [7:0] any_letter();
        return C_LOWER_A + 8'($urandom_range(25));
    endfunction

    // Offer one command, idling at random first, and wait for acceptance
    task automatic send_command(input logic [2:0] op, input logic [7:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.opcode    <= op;
        cmd_ch.char_code <= ch;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (op <= OP_END) accepted_count++;
    endtask

    // Drop valid and hold until every expected pair has been collected
    task automatic settle_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting_pairs != 0) @(posedge i_clk);
    endtask

    // Well-formed run: new key, optional fill, then several messages
    task automatic send_session();
        int         key_len, msg_count, msg_len, pick;
        logic [7:0] prev, ch;
        send_command(OP_START, 8'($urandom));
        key_len = $urandom_range(0, 30);
        for (int i = 0; i < key_len; i++) begin
            if ($urandom_range(9) == 0) ch = 8'($urandom);
            else ch = any_letter();
            send_command(OP_KEY, ch);
        end
        // leave the square partial now and then
        if ($urandom_range(9) != 0) send_command(OP_DONE, 8'($urandom));
        msg_count = $urandom_range(1, 4);
        for (int m = 0; m < msg_count; m++) begin
            msg_len = $urandom_range(1, 16);
            prev    = any_letter();
            for (int i = 0; i < msg_len; i++) begin
                pick = $urandom_range(99);
                if (pick < 25) ch = prev;
                else if (pick < 33) ch = C_SPACE;
                else if (pick < 36) ch = 8'($urandom);
                else ch = any_letter();
                send_command(OP_MSG, ch);
                if (ch != C_SPACE) prev = ch;
            end
            if ($urandom_range(9) != 0) send_command(OP_END, 8'($urandom));
        end
    endtask

    // Short burst of arbitrary commands
    task automatic send_noise();
        int burst;
        burst = $urandom_range(1, 6);
        for (int i = 0; i < burst; i++)
            send_command(3'($urandom_range(7)), 8'($urandom));
    endtask

    // Stimulus and verdict
    initial begin
        cmd_ch.valid     <= 1'b0;
        cmd_ch.opcode    <= OP_START;
        cmd_ch.char_code <= 8'h00;
        i_rst_n          <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: partial key, ignored key bytes, fill, every pairing case
        send_command(OP_START, 8'hff);
        send_command(OP_KEY, "p");
        send_command(OP_KEY, "l");
        send_command(OP_KEY, "a");
        send_command(OP_KEY, "q");
        send_command(OP_KEY, "P");
        send_command(OP_KEY, "p");
        send_command(OP_MSG, "p");
        send_command(OP_MSG, "b");
        send_command(OP_SPARE_5, "a");
        send_command(OP_DONE, 8'h00);
        send_command(OP_KEY, "z");
        send_command(OP_MSG, "h");
        send_command(OP_MSG, "i");
        send_command(OP_MSG, C_SPACE);
        send_command(OP_MSG, "e");
        send_command(OP_MSG, "e");
        send_command(OP_MSG, "z");
        send_command(OP_MSG, "q");
        send_command(OP_MSG, 8'hff);
        send_command(OP_MSG, 8'h00);
        send_command(OP_END, 8'h00);
        send_command(OP_END, 8'hff);
        send_command(OP_SPARE_6, 8'h80);
        send_command(OP_SPARE_7, 8'h7f);
        send_command(OP_MSG, "a");
        send_command(OP_START, 8'h00);

        // Random: three idling phases, pausing for all pairs between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 29; rx_idle_pct = 47; end
                1: begin tx_idle_pct = 47; rx_idle_pct = 29; hold_req = 1'b1; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            while (accepted_count < (phase + 1) * PHASE_COMMANDS) begin
                if ($urandom_range(4) != 0) send_session();
                else send_noise();
            end
            settle_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
